// ----- hdl/pitch_pid_slew_motor_drive_assert.svh -----
// Assertion macros for the pitch drive block
`ifndef PITCH_PID_SLEW_MOTOR_DRIVE_ASSERT_SVH
`define PITCH_PID_SLEW_MOTOR_DRIVE_ASSERT_SVH

// same-cycle implication
`define PPSMD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPSMD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ppsmd_pkg.sv -----
package ppsmd_pkg;

  localparam int PITCH_WIDTH_DEF = 16;
  localparam int Q_FRAC          = 13;
  localparam int US_PER_SEC      = 1000000;

  localparam logic [10:0] PWM_LOW     = 11'd1000;
  localparam logic [10:0] PWM_HIGH    = 11'd2000;
  localparam logic [10:0] PWM_NEUTRAL = 11'd1500;

  // shared unit datapath widths
  localparam int MDU_AW = 72;
  localparam int MDU_QW = 64;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  localparam logic [23:0] PROP_GAIN_RST      = 24'd89600;
  localparam logic [23:0] INTEG_GAIN_RST     = 24'd512;
  localparam logic [23:0] DERIV_GAIN_RST     = 24'd25600;
  localparam logic [45:0] INTEGRAL_BOUND_RST = 46'd1638400000000;
  localparam logic [9:0]  EFFORT_LIMIT_RST   = 10'd400;
  localparam logic [14:0] DEADZONE_HALF_RST  = 15'd715;
  localparam logic [9:0]  SLEW_STEP_RST      = 10'd5;
  localparam logic [10:0] BASE_LEVEL_RST     = 11'd1500;

  typedef enum logic [2:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEG_GAIN     = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_INTEGRAL_BOUND = 3'd3,
    REG_EFFORT_LIMIT   = 3'd4,
    REG_DEADZONE_HALF  = 3'd5,
    REG_SLEW_STEP      = 3'd6,
    REG_BASE_LEVEL     = 3'd7
  } reg_idx_t;

  typedef enum logic {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_sts_t;

endpackage

// ----- hdl/pitch_pid_slew_motor_drive.sv -----
// Pitch PID drive. Each in_ beat is one control step; each out_ beat carries
// both slewed PWM levels, the effort and the active flag. A step inside the
// deadzone, a first step or a step with zero elapsed time goes straight from
// accept to the output state; a full PID step runs the bit-serial
// multiply/divide unit through five multiplies and two 64-bit divides in
// turn. in_ready is high only while the sequencer is idle; a finished result
// may wait in the output register meanwhile. Registers sit on an APB port at
// byte offset 8*index.
module pitch_pid_slew_motor_drive #(
  parameter int PITCH_WIDTH = ppsmd_pkg::PITCH_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [PITCH_WIDTH-1:0] in_pitch,
  input  logic [19:0]                   in_elapsed_us,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [10:0]                   out_motor_a_pwm,
  output logic [10:0]                   out_motor_b_pwm,
  output logic signed [10:0]            out_effort,
  output logic                          out_control_active,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppsmd_pkg::ADDR_W-1:0]  paddr,
  input  logic [ppsmd_pkg::DATA_W-1:0]  pwdata,
  output logic [ppsmd_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import ppsmd_pkg::*;

  localparam int W   = PITCH_WIDTH;
  localparam int MBW = (W + 1 > 24) ? W + 1 : 24;
  localparam int CW  = ((W > 15) ? W : 15) + 2;
  localparam int SW  = 64;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_MES   = 11'b000_0000_0010,
    S_CLAMP = 11'b000_0000_0100,
    S_MP    = 11'b000_0000_1000,
    S_MI    = 11'b000_0001_0000,
    S_DI    = 11'b000_0010_0000,
    S_MKD   = 11'b000_0100_0000,
    S_MD    = 11'b000_1000_0000,
    S_DD    = 11'b001_0000_0000,
    S_FIN   = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_t;

  // config
  logic [23:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [45:0] integral_bound_r;
  logic [9:0]  effort_limit_r, slew_step_r;
  logic [14:0] deadzone_half_r;
  logic [10:0] base_level_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r      <= PROP_GAIN_RST;
      integ_gain_r     <= INTEG_GAIN_RST;
      deriv_gain_r     <= DERIV_GAIN_RST;
      integral_bound_r <= INTEGRAL_BOUND_RST;
      effort_limit_r   <= EFFORT_LIMIT_RST;
      deadzone_half_r  <= DEADZONE_HALF_RST;
      slew_step_r      <= SLEW_STEP_RST;
      base_level_r     <= BASE_LEVEL_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROP_GAIN:      prop_gain_r      <= pwdata[23:0];
        REG_INTEG_GAIN:     integ_gain_r     <= pwdata[23:0];
        REG_DERIV_GAIN:     deriv_gain_r     <= pwdata[23:0];
        REG_INTEGRAL_BOUND: integral_bound_r <= pwdata[45:0];
        REG_EFFORT_LIMIT:   effort_limit_r   <= pwdata[9:0];
        REG_DEADZONE_HALF:  deadzone_half_r  <= pwdata[14:0];
        REG_SLEW_STEP:      slew_step_r      <= pwdata[9:0];
        REG_BASE_LEVEL:     base_level_r     <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PROP_GAIN:      prdata = DATA_W'(prop_gain_r);
      REG_INTEG_GAIN:     prdata = DATA_W'(integ_gain_r);
      REG_DERIV_GAIN:     prdata = DATA_W'(deriv_gain_r);
      REG_INTEGRAL_BOUND: prdata = DATA_W'(integral_bound_r);
      REG_EFFORT_LIMIT:   prdata = DATA_W'(effort_limit_r);
      REG_DEADZONE_HALF:  prdata = DATA_W'(deadzone_half_r);
      REG_SLEW_STEP:      prdata = DATA_W'(slew_step_r);
      REG_BASE_LEVEL:     prdata = DATA_W'(base_level_r);
      default:            prdata = '0;
    endcase
  end

  // slew and saturation helpers
  function automatic logic [10:0] slew(input logic [10:0] lvl, input logic [10:0] tgt,
                                       input logic [9:0] step);
    logic [10:0] gap;
    begin
      if (lvl < tgt) begin
        gap  = tgt - lvl;
        slew = ({1'b0, step} < gap) ? lvl + {1'b0, step} : tgt;
      end else if (lvl > tgt) begin
        gap  = lvl - tgt;
        slew = ({1'b0, step} < gap) ? lvl - {1'b0, step} : tgt;
      end else begin
        slew = lvl;
      end
    end
  endfunction

  function automatic logic [10:0] sat_pwm(input logic [10:0] base,
                                          input logic signed [10:0] eff);
    logic signed [12:0] v;
    begin
      v = $signed({2'b00, base}) - $signed({{2{eff[10]}}, eff});
      if (v < $signed({2'b00, PWM_LOW}))       sat_pwm = PWM_LOW;
      else if (v > $signed({2'b00, PWM_HIGH})) sat_pwm = PWM_HIGH;
      else                                     sat_pwm = v[10:0];
    end
  endfunction

  // control state
  state_t                 state_r, state_nxt;
  logic                   launched_r;
  logic                   first_r;
  logic signed [47:0]     accum_r;
  logic signed [W-1:0]    last_error_r;
  logic [10:0]            target_a_r, target_b_r, level_a_r, level_b_r;
  logic signed [SW-1:0]   sum_r;
  logic signed [10:0]     eff_r;
  logic                   active_r;

  // per-step operands
  logic signed [W-1:0]    e_r;
  logic                   e_neg_r;
  logic [W-2:0]           emag_r;
  logic                   de_neg_r;
  logic [W-1:0]           demag_r;
  logic [19:0]            span_r;

  // output register
  logic                   out_valid_r;
  logic [10:0]            out_a_r, out_b_r;
  logic signed [10:0]     out_eff_r;
  logic                   out_act_r;

  // input decode
  logic signed [CW-1:0]   p_x, dz_x;
  logic                   in_active;
  logic signed [W-1:0]    e_in, e_abs;
  logic signed [W:0]      de_in, de_abs;
  logic                   in_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid & in_ready;

  assign p_x       = {{(CW-W){in_pitch[W-1]}}, in_pitch};
  assign dz_x      = {{(CW-15){1'b0}}, deadzone_half_r};
  assign in_active = (p_x > dz_x) || (p_x < -dz_x);
  assign e_in      = (in_pitch == {1'b1, {(W-1){1'b0}}}) ? {1'b0, {(W-1){1'b1}}} : -in_pitch;
  assign e_abs     = e_in[W-1] ? -e_in : e_in;
  assign de_in     = {e_in[W-1], e_in} - {last_error_r[W-1], last_error_r};
  assign de_abs    = de_in[W] ? -de_in : de_in;

  // shared unit
  mdu_req_t              mdu_req;
  mdu_sts_t              mdu_sts;
  logic [MDU_AW-1:0]     mdu_a, mdu_res;
  logic [MBW-1:0]        mdu_b;
  logic [47:0]           acc_mag;
  logic                  op_state;

  assign acc_mag  = accum_r[47] ? 48'(-accum_r) : 48'(accum_r);
  assign op_state = (state_r == S_MES) || (state_r == S_MP) || (state_r == S_MI) ||
                    (state_r == S_DI) || (state_r == S_MKD) || (state_r == S_MD) ||
                    (state_r == S_DD);

  always_comb begin
    mdu_a         = '0;
    mdu_b         = '0;
    mdu_req.op    = MDU_MUL;
    mdu_req.start = op_state & ~launched_r;
    case (state_r)
      S_MES: begin
        mdu_a = MDU_AW'(span_r);
        mdu_b = MBW'(emag_r);
      end
      S_MP: begin
        mdu_a = MDU_AW'(prop_gain_r);
        mdu_b = MBW'(emag_r);
      end
      S_MI: begin
        mdu_a = MDU_AW'(acc_mag);
        mdu_b = MBW'(integ_gain_r);
      end
      S_DI: begin
        mdu_req.op = MDU_DIV;
        mdu_a      = mdu_res >> Q_FRAC;
        mdu_b      = MBW'(US_PER_SEC);
      end
      S_MKD: begin
        mdu_a = MDU_AW'(US_PER_SEC);
        mdu_b = MBW'(deriv_gain_r);
      end
      S_MD: begin
        mdu_a = mdu_res;
        mdu_b = MBW'(demag_r);
      end
      S_DD: begin
        mdu_req.op = MDU_DIV;
        mdu_a      = mdu_res >> Q_FRAC;
        mdu_b      = MBW'(span_r);
      end
      default: ;
    endcase
  end

  ppsmd_mdu #(
    .BW (MBW)
  ) u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mdu_req),
    .opa   (mdu_a),
    .opb   (mdu_b),
    .sts   (mdu_sts),
    .res   (mdu_res)
  );

  // term and final effort
  logic signed [SW-1:0]  term;
  logic signed [SW-1:0]  sum_abs;
  logic [SW-9:0]         mag;
  logic [9:0]            mclip;
  logic signed [10:0]    eff_fin;
  logic signed [47:0]    bound_x;
  logic                  out_load;

  assign term    = (state_r == S_MP) ? SW'(mdu_res >> Q_FRAC) : SW'(mdu_res[MDU_QW-1:0]);
  assign sum_abs = sum_r[SW-1] ? -sum_r : sum_r;
  assign mag     = sum_abs[SW-1:8];
  assign mclip   = (mag > (SW-8)'(effort_limit_r)) ? effort_limit_r : mag[9:0];
  assign eff_fin = sum_r[SW-1] ? -$signed({1'b0, mclip}) : $signed({1'b0, mclip});
  assign bound_x = $signed({2'b00, integral_bound_r});
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_active || first_r || in_elapsed_us == '0) state_nxt = S_OUT;
          else                                               state_nxt = S_MES;
        end
      end
      S_MES:   if (mdu_sts.done) state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_MP;
      S_MP:    if (mdu_sts.done) state_nxt = S_MI;
      S_MI:    if (mdu_sts.done) state_nxt = S_DI;
      S_DI:    if (mdu_sts.done) state_nxt = S_MKD;
      S_MKD:   if (mdu_sts.done) state_nxt = S_MD;
      S_MD:    if (mdu_sts.done) state_nxt = S_DD;
      S_DD:    if (mdu_sts.done) state_nxt = S_FIN;
      S_FIN:   state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      launched_r   <= 1'b0;
      first_r      <= 1'b1;
      accum_r      <= '0;
      last_error_r <= '0;
      target_a_r   <= PWM_NEUTRAL;
      target_b_r   <= PWM_NEUTRAL;
      level_a_r    <= PWM_NEUTRAL;
      level_b_r    <= PWM_NEUTRAL;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mdu_req.start)     launched_r <= 1'b1;
      else if (mdu_sts.done) launched_r <= 1'b0;

      if (in_acc) begin
        if (!in_active) begin
          accum_r      <= '0;
          last_error_r <= '0;
          first_r      <= 1'b1;
        end else if (first_r || in_elapsed_us == '0) begin
          first_r    <= 1'b0;
          target_a_r <= sat_pwm(base_level_r, 11'sd0);
          target_b_r <= sat_pwm(base_level_r, 11'sd0);
        end
      end

      if (state_r == S_MES && mdu_sts.done) begin
        accum_r <= e_neg_r ? accum_r - $signed(mdu_res[47:0])
                           : accum_r + $signed(mdu_res[47:0]);
      end
      if (state_r == S_CLAMP) begin
        if (accum_r > bound_x)       accum_r <= bound_x;
        else if (accum_r < -bound_x) accum_r <= -bound_x;
      end
      if (state_r == S_DD && mdu_sts.done) last_error_r <= e_r;
      if (state_r == S_FIN) begin
        target_a_r <= sat_pwm(base_level_r, eff_fin);
        target_b_r <= sat_pwm(base_level_r, eff_fin);
      end

      if (out_load) begin
        level_a_r   <= slew(level_a_r, target_a_r, slew_step_r);
        level_b_r   <= slew(level_b_r, target_b_r, slew_step_r);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      e_r      <= e_in;
      e_neg_r  <= e_in[W-1];
      emag_r   <= e_abs[W-2:0];
      de_neg_r <= de_in[W];
      demag_r  <= de_abs[W-1:0];
      span_r   <= in_elapsed_us;
      active_r <= in_active;
      eff_r    <= '0;
    end
    if (state_r == S_MP && mdu_sts.done) sum_r <= e_neg_r ? -term : term;
    if (state_r == S_DI && mdu_sts.done) sum_r <= accum_r[47] ? sum_r - term : sum_r + term;
    if (state_r == S_DD && mdu_sts.done) sum_r <= de_neg_r ? sum_r - term : sum_r + term;
    if (state_r == S_FIN) eff_r <= eff_fin;
    if (out_load) begin
      out_a_r   <= slew(level_a_r, target_a_r, slew_step_r);
      out_b_r   <= slew(level_b_r, target_b_r, slew_step_r);
      out_eff_r <= eff_r;
      out_act_r <= active_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_motor_a_pwm    = out_a_r;
  assign out_motor_b_pwm    = out_b_r;
  assign out_effort         = out_eff_r;
  assign out_control_active = out_act_r;

  `include "pitch_pid_slew_motor_drive_assert.svh"

  `PPSMD_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ready, "ready after accept")
  `PPSMD_ASSERT_IMP(a_pwm_range, out_valid,
    out_motor_a_pwm >= PWM_LOW && out_motor_a_pwm <= PWM_HIGH &&
    out_motor_b_pwm >= PWM_LOW && out_motor_b_pwm <= PWM_HIGH, "pwm out of range")
  `PPSMD_ASSERT_IMP(a_done_in_op, mdu_sts.done, op_state, "unit done outside op state")

endmodule

// ----- hdl/ppsmd_mdu.sv -----
module ppsmd_mdu #(
  parameter int BW = 25
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ppsmd_pkg::mdu_req_t        req,
  input  logic [ppsmd_pkg::MDU_AW-1:0] opa,
  input  logic [BW-1:0]              opb,
  output ppsmd_pkg::mdu_sts_t        sts,
  output logic [ppsmd_pkg::MDU_AW-1:0] res
);
  import ppsmd_pkg::*;

  localparam int CNTW = $clog2(MDU_QW);

  logic            busy_r;
  logic            done_r;
  mdu_op_t         op_r;
  logic [CNTW-1:0] cnt_r;
  logic [MDU_AW-1:0] acc_r;
  logic [MDU_AW-1:0] a_r;
  logic [BW-1:0]   b_r;
  logic [BW-1:0]   rem_r;

  logic [BW:0]     rem_sh;
  logic [BW:0]     diff;
  logic            fits;

  assign rem_sh = {rem_r, acc_r[MDU_QW-1]};
  assign diff   = rem_sh - {1'b0, b_r};
  assign fits   = ~diff[BW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (req.op == MDU_MUL) ? CNTW'(BW - 1) : CNTW'(MDU_QW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      acc_r <= (req.op == MDU_MUL) ? '0 : opa;
      a_r   <= opa;
      b_r   <= opb;
      rem_r <= '0;
    end else if (busy_r) begin
      case (op_r)
        MDU_MUL: begin
          if (b_r[0]) acc_r <= acc_r + a_r;
          a_r <= a_r << 1;
          b_r <= b_r >> 1;
        end
        MDU_DIV: begin
          rem_r <= fits ? diff[BW-1:0] : rem_sh[BW-1:0];
          acc_r <= MDU_AW'({acc_r[MDU_QW-2:0], fits});
        end
        default: acc_r <= acc_r;
      endcase
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign res      = acc_r;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import ppsmd_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [10:0]        pwm_a;
    logic [10:0]        pwm_b;
    logic signed [10:0] effort;
    logic               active;
  } drive_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_pitch;
  logic [19:0]        in_elapsed_us;
  logic               out_valid;
  logic               out_ready;
  logic [10:0]        out_motor_a_pwm;
  logic [10:0]        out_motor_b_pwm;
  logic signed [10:0] out_effort;
  logic               out_control_active;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  pitch_pid_slew_motor_drive uut (.*);

  // predictor copy of registers and state
  longint unsigned kp, ki, kd, ibound, elim, dzone, slew_lim, base_lvl;
  longint          integ_sum, prev_err;
  bit              first_pending;
  longint          tgt_a, tgt_b, lvl_a, lvl_b;

  drive_result_t step_results_q[$];
  int            err_count;
  int            burst_left;
  int            hold_cnt;
  int            rx_mode;
  longint        cycle_cnt;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[pitch_pid_slew_motor_drive] ERROR");
      $finish;
    end
  end

  function automatic longint unsigned scaled_quot(longint unsigned a, longint unsigned b,
                                                  longint unsigned d);
    logic [127:0] q;
    q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
    return (q > (128'd1 << 60)) ? (64'd1 << 60) : q[63:0];
  endfunction

  function automatic longint sat_pwm(longint v);
    return v < 1000 ? 1000 : (v > 2000 ? 2000 : v);
  endfunction

  function automatic longint slew_to(longint lvl, longint tgt);
    longint s;
    s = longint'(slew_lim);
    if (lvl < tgt) return (lvl + s < tgt) ? lvl + s : tgt;
    if (lvl > tgt) return (lvl - s > tgt) ? lvl - s : tgt;
    return lvl;
  endfunction

  function automatic longint signed_term(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic drive_result_t drive_model_step(logic signed [15:0] p, logic [19:0] dt);
    drive_result_t   r;
    longint          pitch, e, de, sum, eff, bnd;
    longint unsigned m;
    bit              act;
    pitch = p;
    eff = 0;
    act = (pitch > longint'(dzone)) || (pitch < -longint'(dzone));
    if (!act) begin
      integ_sum = 0;
      prev_err = 0;
      first_pending = 1;
    end else begin
      if (first_pending || dt == 0) begin
        first_pending = 0;
      end else begin
        e = -pitch;
        if (e > 32767) e = 32767;
        bnd = longint'(ibound);
        integ_sum += e * longint'(dt);
        if (integ_sum > bnd) integ_sum = bnd;
        else if (integ_sum < -bnd) integ_sum = -bnd;
        de = e - prev_err;
        sum = signed_term(scaled_quot(kp, e < 0 ? -e : e, 64'd1 << 13), e < 0);
        sum += signed_term(scaled_quot(ki, integ_sum < 0 ? -integ_sum : integ_sum,
                                       (64'd1 << 13) * 64'd1000000), integ_sum < 0);
        sum += signed_term(scaled_quot(kd * 64'd1000000, de < 0 ? -de : de,
                                       (64'd1 << 13) * longint'(dt)), de < 0);
        m = (sum < 0 ? -sum : sum) >> 8;
        if (m > elim) m = elim;
        eff = signed_term(m, sum < 0);
        prev_err = e;
      end
      tgt_a = sat_pwm(longint'(base_lvl) - eff);
      tgt_b = sat_pwm(longint'(base_lvl) - eff);
    end
    lvl_a = slew_to(lvl_a, tgt_a);
    lvl_b = slew_to(lvl_b, tgt_b);
    r.pwm_a = lvl_a[10:0];
    r.pwm_b = lvl_b[10:0];
    r.effort = eff[10:0];
    r.active = act;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
    err_count++;
  endtask

  always @(posedge clk) begin
    drive_result_t w;
    if (rst_n && out_valid && out_ready) begin
      if (step_results_q.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        w = step_results_q.pop_front();
        if (out_motor_a_pwm !== w.pwm_a) report_mismatch("motor_a_pwm", out_motor_a_pwm, w.pwm_a);
        if (out_motor_b_pwm !== w.pwm_b) report_mismatch("motor_b_pwm", out_motor_b_pwm, w.pwm_b);
        if (out_effort !== w.effort) report_mismatch("effort", out_effort, w.effort);
        if (out_control_active !== w.active)
          report_mismatch("control_active", out_control_active, w.active);
      end
    end
  end

  // receiver stall pattern, with a counted long hold-off
  always @(negedge clk) begin
    if (cycle_cnt % 97 == 0) rx_mode <= $urandom_range(0, 2);
    if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [63:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(idx) << 3;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PROP_GAIN:      kp = v[23:0];
      REG_INTEG_GAIN:     ki = v[23:0];
      REG_DERIV_GAIN:     kd = v[23:0];
      REG_INTEGRAL_BOUND: ibound = v[45:0];
      REG_EFFORT_LIMIT:   elim = v[9:0];
      REG_DEADZONE_HALF:  dzone = v[14:0];
      REG_SLEW_STEP:      slew_lim = v[9:0];
      default:            base_lvl = v[10:0];
    endcase
  endtask

  task automatic cfg_all(longint unsigned p, longint unsigned i, longint unsigned d,
                         longint unsigned b, longint unsigned el, longint unsigned dz,
                         longint unsigned sl, longint unsigned bl);
    cfg_write(REG_PROP_GAIN, p);
    cfg_write(REG_INTEG_GAIN, i);
    cfg_write(REG_DERIV_GAIN, d);
    cfg_write(REG_INTEGRAL_BOUND, b);
    cfg_write(REG_EFFORT_LIMIT, el);
    cfg_write(REG_DEADZONE_HALF, dz);
    cfg_write(REG_SLEW_STEP, sl);
    cfg_write(REG_BASE_LEVEL, bl);
  endtask

  task automatic send_step(logic signed [15:0] p, logic [19:0] dt);
    if (burst_left <= 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end else begin
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pitch <= p;
    in_elapsed_us <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    step_results_q.push_back(drive_model_step(p, dt));
    burst_left--;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (step_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_random_step();
    logic signed [15:0] p;
    logic [19:0]        dt;
    int                 sel;
    sel = $urandom_range(0, 99);
    p = 16'($urandom);
    if (sel < 10) p = 16'(int'($urandom_range(0, 2 * dzone)) - int'(dzone));
    sel = $urandom_range(0, 99);
    if (sel < 5) dt = '0;
    else if (sel < 60) dt = 20'($urandom_range(1, 20000));
    else dt = 20'($urandom_range(1, 1000000));
    send_step(p, dt);
  endtask

  task automatic test_directed();
    send_step(16'sd0, 20'd10000);
    send_step(16'sd2000, 20'd10000);
    send_step(16'sd2000, 20'd10000);
    send_step(-16'sd3000, 20'd0);
    send_step(-16'sd3000, 20'd1);
    send_step(16'sd715, 20'd5000);
    send_step(-16'sd715, 20'd5000);
    send_step(16'sd716, 20'd5000);
    send_step(-16'sd716, 20'd1000000);
    send_step(-16'sd32768, 20'd1000000);
    send_step(16'sd32767, 20'd1000000);
    send_step(-16'sd32768, 20'd1);
    send_step(16'sd32767, 20'd524288);
    send_step(16'sd8192, 20'd999999);
    send_step(-16'sd8192, 20'd10000);
    wait_drained();
  endtask

  task automatic test_extremes();
    cfg_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, (64'd1 << 46) - 1, 1023, 0, 1023, 2047);
    for (int k = 0; k < 12; k++) send_random_step();
    send_step(16'sd0, 20'd100);
    wait_drained();
    cfg_all(0, 0, 0, 0, 0, 32767, 0, 0);
    for (int k = 0; k < 6; k++) send_random_step();
    send_step(-16'sd32768, 20'd100);
    send_step(16'sd32767, 20'd100);
    wait_drained();
    cfg_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1000, 1000, 0, 1000, 1000);
    for (int k = 0; k < 10; k++) send_random_step();
    wait_drained();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0)
        cfg_all(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, INTEGRAL_BOUND_RST,
                EFFORT_LIMIT_RST, DEADZONE_HALF_RST, SLEW_STEP_RST, BASE_LEVEL_RST);
      else
        cfg_all($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 16),
                $urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 16),
                $urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 16),
                {$urandom, $urandom} >> $urandom_range(18, 40),
                $urandom_range(0, 1023), $urandom_range(0, 32767) >> $urandom_range(0, 10),
                $urandom_range(0, 1023) >> $urandom_range(0, 9),
                $urandom_range(0, 9) == 0 ? $urandom_range(0, 2047) : $urandom_range(1000, 2000));
      for (int k = 0; k < 52; k++) send_random_step();
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    hold_cnt = 3000;
    for (int k = 0; k < 8; k++) send_random_step();
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pitch = '0;
    in_elapsed_us = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    err_count = 0;
    burst_left = 0;
    hold_cnt = 0;
    rx_mode = 0;
    cycle_cnt = 0;
    kp = PROP_GAIN_RST;
    ki = INTEG_GAIN_RST;
    kd = DERIV_GAIN_RST;
    ibound = INTEGRAL_BOUND_RST;
    elim = EFFORT_LIMIT_RST;
    dzone = DEADZONE_HALF_RST;
    slew_lim = SLEW_STEP_RST;
    base_lvl = BASE_LEVEL_RST;
    integ_sum = 0;
    prev_err = 0;
    first_pending = 1;
    tgt_a = 1500;
    tgt_b = 1500;
    lvl_a = 1500;
    lvl_b = 1500;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(negedge clk);

    test_directed();
    test_extremes();
    test_backpressure();
    test_random_phases();
    test_backpressure();

    repeat (300) @(posedge clk);
    if (err_count == 0 && step_results_q.size() == 0) begin
      $display("[pitch_pid_slew_motor_drive] OK");
    end else begin
      $display("[pitch_pid_slew_motor_drive] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/ppsmd_pkg.sv
hdl/ppsmd_mdu.sv
hdl/pitch_pid_slew_motor_drive.sv
verif/tb_top.sv
